// ===== hw/rtl/view_vector_rotator_top_macros.svh =====
// Assertion helpers for the view vector rotator.
// Both expect clk_i and rst_ni in the scope where they are used.
`ifndef VIEW_VECTOR_ROTATOR_TOP_MACROS_SVH
`define VIEW_VECTOR_ROTATOR_TOP_MACROS_SVH

// Plain property, checked on every rising edge outside reset.
`define VVR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Antecedent in one cycle, consequent in the next.
`define VVR_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/vvr_pkg.sv =====
`default_nettype none

package vvr_pkg;

  localparam int VEC_WIDTH    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int GUARD_BITS   = 6;
  localparam int ATAN_COUNT   = 24;

  localparam int FIELD_W   = 16;
  localparam int SENS_W    = 10;
  localparam int DX_W      = 11;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int BAU_W     = 16;

  localparam int STEPS_USED = (CORDIC_STEPS < 1) ? 1 :
                              ((CORDIC_STEPS > ATAN_COUNT) ? ATAN_COUNT : CORDIC_STEPS);
  localparam int STEP_W     = (STEPS_USED > 1) ? $clog2(STEPS_USED) : 1;

  // CORDIC working width: guard bits plus headroom for gain and quadrant negate
  localparam int XW     = VEC_WIDTH + GUARD_BITS + 3;
  localparam int MUL_W  = (XW > 25) ? XW : 25;
  localparam int PROD_W = 2 * MUL_W;
  localparam int Z_W    = 34;

  localparam int     ROUND_SHIFT      = 24 + GUARD_BITS;
  localparam longint GAIN_Q24         = 64'd10188014 + (64'd6792009 >> (2 * STEPS_USED));
  localparam longint BAU_PER_MRAD_Q16 = 683565;

  localparam logic signed [PROD_W-1:0] VEC_MAX =
    PROD_W'((64'sd1 <<< (VEC_WIDTH - 1)) - 64'sd1);
  localparam logic signed [PROD_W-1:0] VEC_MIN = ~VEC_MAX;

  localparam logic REQ_RELOAD = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SENS    = 3'd0,
    CFG_DIR_X   = 3'd1,
    CFG_DIR_Y   = 3'd2,
    CFG_PLANE_X = 3'd3,
    CFG_PLANE_Y = 3'd4
  } cfg_idx_e;

  localparam logic [SENS_W-1:0] SENS_RST    = 10'd50;
  localparam logic [CFG_W-1:0]  DIR_X_RST   = 16'd16384;
  localparam logic [CFG_W-1:0]  DIR_Y_RST   = 16'd0;
  localparam logic [CFG_W-1:0]  PLANE_X_RST = 16'd0;
  localparam logic [CFG_W-1:0]  PLANE_Y_RST = 16'd10813;

  typedef struct packed {
    logic              load;
    logic              step;
    logic [STEP_W-1:0] idx;
  } cdc_ctrl_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic [29:0] atan_lut(input logic [4:0] i);
    case (i)
      5'd0:    return 30'd536870912;
      5'd1:    return 30'd316933406;
      5'd2:    return 30'd167458907;
      5'd3:    return 30'd85004756;
      5'd4:    return 30'd42667331;
      5'd5:    return 30'd21354465;
      5'd6:    return 30'd10679838;
      5'd7:    return 30'd5340245;
      5'd8:    return 30'd2670163;
      5'd9:    return 30'd1335086;
      5'd10:   return 30'd667544;
      5'd11:   return 30'd333772;
      5'd12:   return 30'd166886;
      5'd13:   return 30'd83443;
      5'd14:   return 30'd41721;
      5'd15:   return 30'd20860;
      5'd16:   return 30'd10430;
      5'd17:   return 30'd5215;
      5'd18:   return 30'd2607;
      5'd19:   return 30'd1303;
      5'd20:   return 30'd651;
      5'd21:   return 30'd325;
      5'd22:   return 30'd162;
      5'd23:   return 30'd81;
      default: return 30'd0;
    endcase
  endfunction

  function automatic logic signed [VEC_WIDTH-1:0] sat_vec(input logic signed [PROD_W-1:0] v);
    if (v > VEC_MAX) begin
      return VEC_MAX[VEC_WIDTH-1:0];
    end else if (v < VEC_MIN) begin
      return VEC_MIN[VEC_WIDTH-1:0];
    end
    return v[VEC_WIDTH-1:0];
  endfunction

  function automatic logic signed [VEC_WIDTH-1:0] reload_val(input logic [CFG_W-1:0] v);
    return sat_vec(PROD_W'($signed(v)));
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(input logic signed [VEC_WIDTH-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[FIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vvr_req_if.sv =====
`default_nettype none

interface vvr_req_if;
  logic                            valid;
  logic                            ready;
  logic                            req_type;
  logic signed [vvr_pkg::DX_W-1:0] mouse_dx;
  logic                            active;

  modport source (output valid, req_type, mouse_dx, active, input ready);
  modport sink   (input valid, req_type, mouse_dx, active, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/vvr_res_if.sv =====
`default_nettype none

interface vvr_res_if;
  logic                         valid;
  logic                         ready;
  logic [vvr_pkg::FIELD_W-1:0]  dir_x_out;
  logic [vvr_pkg::FIELD_W-1:0]  dir_y_out;
  logic [vvr_pkg::FIELD_W-1:0]  plane_x_out;
  logic [vvr_pkg::FIELD_W-1:0]  plane_y_out;

  modport source (output valid, dir_x_out, dir_y_out, plane_x_out, plane_y_out,
                  input ready);
  modport sink   (input valid, dir_x_out, dir_y_out, plane_x_out, plane_y_out,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/vvr_mul.sv =====
`default_nettype none

// Shared signed multiplier, product registered.
module vvr_mul (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [vvr_pkg::MUL_W-1:0]  a_i,
  input  logic signed [vvr_pkg::MUL_W-1:0]  b_i,
  output logic signed [vvr_pkg::PROD_W-1:0] p_o
);

  localparam int PW = vvr_pkg::PROD_W;

  logic signed [PW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= PW'(a_i) * PW'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// ===== hw/rtl/vvr_cordic.sv =====
`default_nettype none

// One micro-rotation per cycle, applied to both vectors with a shared angle.
module vvr_cordic (
  input  logic                                 clk_i,
  input  vvr_pkg::cdc_ctrl_t                   ctrl_i,
  input  logic [vvr_pkg::BAU_W-1:0]            bau_i,
  input  logic signed [vvr_pkg::VEC_WIDTH-1:0] dir_x_i,
  input  logic signed [vvr_pkg::VEC_WIDTH-1:0] dir_y_i,
  input  logic signed [vvr_pkg::VEC_WIDTH-1:0] plane_x_i,
  input  logic signed [vvr_pkg::VEC_WIDTH-1:0] plane_y_i,
  output logic signed [vvr_pkg::XW-1:0]        dir_x_o,
  output logic signed [vvr_pkg::XW-1:0]        dir_y_o,
  output logic signed [vvr_pkg::XW-1:0]        plane_x_o,
  output logic signed [vvr_pkg::XW-1:0]        plane_y_o
);

  localparam int VW = vvr_pkg::VEC_WIDTH;
  localparam int XW = vvr_pkg::XW;
  localparam int ZW = vvr_pkg::Z_W;
  localparam int GB = vvr_pkg::GUARD_BITS;

  logic signed [XW-1:0] dx_q, dy_q, px_q, py_q;
  logic signed [XW-1:0] dx_d, dy_d, px_d, py_d;
  logic signed [ZW-1:0] z_q, z_d;

  logic signed [16:0]   z17, zadj;
  logic                 wrap;
  logic signed [ZW-1:0] atan_v;
  logic signed [XW-1:0] sh_dx, sh_dy, sh_px, sh_py;

  function automatic logic signed [XW-1:0] widen(input logic signed [VW-1:0] v,
                                                  input logic neg);
    logic signed [XW-1:0] w;
    w = XW'(v) <<< GB;
    return neg ? -w : w;
  endfunction

  // beyond a quarter turn: negate vectors and fold the angle by a half turn
  always_comb begin
    z17  = 17'($signed(bau_i));
    wrap = (z17 > 17'sd16384) || (z17 < -17'sd16384);
    zadj = z17;
    if (z17 > 17'sd16384) begin
      zadj = z17 - 17'sd32768;
    end else if (z17 < -17'sd16384) begin
      zadj = z17 + 17'sd32768;
    end
  end

  always_comb begin
    atan_v = ZW'(vvr_pkg::atan_lut(5'(ctrl_i.idx)));
    sh_dx  = dx_q >>> ctrl_i.idx;
    sh_dy  = dy_q >>> ctrl_i.idx;
    sh_px  = px_q >>> ctrl_i.idx;
    sh_py  = py_q >>> ctrl_i.idx;
    dx_d   = dx_q;
    dy_d   = dy_q;
    px_d   = px_q;
    py_d   = py_q;
    z_d    = z_q;
    if (ctrl_i.load) begin
      dx_d = widen(dir_x_i, wrap);
      dy_d = widen(dir_y_i, wrap);
      px_d = widen(plane_x_i, wrap);
      py_d = widen(plane_y_i, wrap);
      z_d  = ZW'(zadj) <<< 16;
    end else if (ctrl_i.step) begin
      if (!z_q[ZW-1]) begin
        dx_d = dx_q - sh_dy;
        dy_d = dy_q + sh_dx;
        px_d = px_q - sh_py;
        py_d = py_q + sh_px;
        z_d  = z_q - atan_v;
      end else begin
        dx_d = dx_q + sh_dy;
        dy_d = dy_q - sh_dx;
        px_d = px_q + sh_py;
        py_d = py_q - sh_px;
        z_d  = z_q + atan_v;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q <= dx_d;
    dy_q <= dy_d;
    px_q <= px_d;
    py_q <= py_d;
    z_q  <= z_d;
  end

  assign dir_x_o   = dx_q;
  assign dir_y_o   = dy_q;
  assign plane_x_o = px_q;
  assign plane_y_o = py_q;

endmodule

`default_nettype wire

// ===== hw/rtl/view_vector_rotator_top.sv =====
`default_nettype none

// Channel  Dir  Modport  Word
// -------  ---  -------  ----------------------------------------------
// req_i    in   sink     req_type, mouse_dx (s11), active
// res_o    out  source   dir_x_out, dir_y_out, plane_x_out, plane_y_out
// cfg      in   -        cfg_we_i / cfg_idx_i / cfg_wdata_i, write only
//
// Rotate word, in order from one accept to the next: the accepting cycle, two multiplier
// passes for the angle, the angle step, one micro-rotation per cycle for each CORDIC step,
// four gain passes plus one drain, one output load.
// Reload or inactive word: straight to the output load. Zero angle: no rotation or gain.
// Reset loads the vectors from the reset start values; no clearing pass.
// A finished word waits in the output register; the next one stalls until it empties.
module view_vector_rotator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [vvr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [vvr_pkg::CFG_W-1:0]       cfg_wdata_i,
  vvr_req_if.sink                         req_i,
  vvr_res_if.source                       res_o
);

  localparam int VW  = vvr_pkg::VEC_WIDTH;
  localparam int XW  = vvr_pkg::XW;
  localparam int MW  = vvr_pkg::MUL_W;
  localparam int PW  = vvr_pkg::PROD_W;
  localparam int SW  = vvr_pkg::STEP_W;
  localparam int RS  = vvr_pkg::ROUND_SHIFT;

  localparam logic signed [MW-1:0] GAIN_OP  = MW'(vvr_pkg::GAIN_Q24);
  localparam logic signed [MW-1:0] ANGLE_OP = MW'(vvr_pkg::BAU_PER_MRAD_Q16);
  localparam logic signed [PW-1:0] ROUND_ADD = PW'(64'sd1 <<< (RS - 1));
  localparam logic [SW-1:0]        LAST_STEP = SW'(vvr_pkg::STEPS_USED - 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PROD  = 8'b0000_0010,  // dx * sensitivity
    S_ANG   = 8'b0000_0100,  // * binary angle constant
    S_ANGLE = 8'b0000_1000,  // round, wrap, load CORDIC
    S_ROT   = 8'b0001_0000,
    S_GAIN  = 8'b0010_0000,  // feed components to multiplier
    S_GLAST = 8'b0100_0000,  // write back last component
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic [SW-1:0] cnt_q, cnt_d;
  logic [1:0]    gsel_q, gsel_d;

  // configuration
  logic [vvr_pkg::SENS_W-1:0] sens_q;
  logic [vvr_pkg::CFG_W-1:0]  start_dir_x_q, start_dir_y_q;
  logic [vvr_pkg::CFG_W-1:0]  start_plane_x_q, start_plane_y_q;

  // vector state
  logic signed [VW-1:0] dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic signed [vvr_pkg::DX_W-1:0] dx_q;

  // output register
  logic                        out_valid_q;
  logic [vvr_pkg::FIELD_W-1:0] dir_x_out_q, dir_y_out_q, plane_x_out_q, plane_y_out_q;

  logic in_acc, out_load, reload_en, wb_en;
  logic [1:0] wb_sel;

  logic                 mul_en;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;

  vvr_pkg::cdc_ctrl_t   cdc_ctrl;
  logic signed [XW-1:0] cx_dir, cy_dir, cx_pl, cy_pl;

  logic [31:0]                ang_u;
  logic [vvr_pkg::BAU_W-1:0]  bau;
  logic signed [VW-1:0]       gain_res;
  logic signed [XW-1:0]       gain_in;

  assign req_i.ready = (state_q == S_IDLE);
  assign in_acc      = req_i.valid && req_i.ready;
  assign out_load    = (state_q == S_DONE) && !out_valid_q;

  // binary angle: round half up, keep low 16 bits of the turn
  assign ang_u    = 32'd0 - mul_p[31:0] + 32'd32768;
  assign bau      = ang_u[31:16];
  assign gain_res = vvr_pkg::sat_vec((mul_p + ROUND_ADD) >>> RS);

  always_comb begin
    case (gsel_q)
      2'd0: gain_in = cx_dir;
      2'd1: gain_in = cy_dir;
      2'd2: gain_in = cx_pl;
      2'd3: gain_in = cy_pl;
    endcase
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    gsel_d    = gsel_q;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    cdc_ctrl  = '0;
    reload_en = 1'b0;
    wb_en     = 1'b0;
    wb_sel    = gsel_q - 2'd1;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          if (req_i.req_type == vvr_pkg::REQ_RELOAD) begin
            reload_en = 1'b1;
            state_d   = S_DONE;
          end else if (!req_i.active) begin
            state_d = S_DONE;
          end else begin
            state_d = S_PROD;
          end
        end
      end
      S_PROD: begin
        mul_en  = 1'b1;
        mul_a   = MW'(dx_q);
        mul_b   = MW'($signed({1'b0, sens_q}));
        state_d = S_ANG;
      end
      S_ANG: begin
        mul_en  = 1'b1;
        mul_a   = mul_p[MW-1:0];
        mul_b   = ANGLE_OP;
        state_d = S_ANGLE;
      end
      S_ANGLE: begin
        if (bau == '0) begin
          state_d = S_DONE;
        end else begin
          cdc_ctrl.load = 1'b1;
          cnt_d         = '0;
          state_d       = S_ROT;
        end
      end
      S_ROT: begin
        cdc_ctrl.step = 1'b1;
        cdc_ctrl.idx  = cnt_q;
        cnt_d         = cnt_q + SW'(1);
        if (cnt_q == LAST_STEP) begin
          gsel_d  = 2'd0;
          state_d = S_GAIN;
        end
      end
      S_GAIN: begin
        mul_en = 1'b1;
        mul_a  = MW'(gain_in);
        mul_b  = GAIN_OP;
        wb_en  = (gsel_q != 2'd0);
        gsel_d = gsel_q + 2'd1;
        if (gsel_q == 2'd3) begin
          state_d = S_GLAST;
        end
      end
      S_GLAST: begin
        wb_en   = 1'b1;
        wb_sel  = 2'd3;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      gsel_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      gsel_q  <= gsel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dx_q <= req_i.mouse_dx;
    end
  end

  // configuration writes; unknown indexes fall through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_q          <= vvr_pkg::SENS_RST;
      start_dir_x_q   <= vvr_pkg::DIR_X_RST;
      start_dir_y_q   <= vvr_pkg::DIR_Y_RST;
      start_plane_x_q <= vvr_pkg::PLANE_X_RST;
      start_plane_y_q <= vvr_pkg::PLANE_Y_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        vvr_pkg::CFG_SENS:    sens_q          <= cfg_wdata_i[vvr_pkg::SENS_W-1:0];
        vvr_pkg::CFG_DIR_X:   start_dir_x_q   <= cfg_wdata_i;
        vvr_pkg::CFG_DIR_Y:   start_dir_y_q   <= cfg_wdata_i;
        vvr_pkg::CFG_PLANE_X: start_plane_x_q <= cfg_wdata_i;
        vvr_pkg::CFG_PLANE_Y: start_plane_y_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // vector state: reload on accept, gain write-back after rotation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_x_q   <= vvr_pkg::reload_val(vvr_pkg::DIR_X_RST);
      dir_y_q   <= vvr_pkg::reload_val(vvr_pkg::DIR_Y_RST);
      plane_x_q <= vvr_pkg::reload_val(vvr_pkg::PLANE_X_RST);
      plane_y_q <= vvr_pkg::reload_val(vvr_pkg::PLANE_Y_RST);
    end else if (reload_en) begin
      dir_x_q   <= vvr_pkg::reload_val(start_dir_x_q);
      dir_y_q   <= vvr_pkg::reload_val(start_dir_y_q);
      plane_x_q <= vvr_pkg::reload_val(start_plane_x_q);
      plane_y_q <= vvr_pkg::reload_val(start_plane_y_q);
    end else if (wb_en) begin
      case (wb_sel)
        2'd0: dir_x_q   <= gain_res;
        2'd1: dir_y_q   <= gain_res;
        2'd2: plane_x_q <= gain_res;
        2'd3: plane_y_q <= gain_res;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      dir_x_out_q   <= vvr_pkg::to_field(dir_x_q);
      dir_y_out_q   <= vvr_pkg::to_field(dir_y_q);
      plane_x_out_q <= vvr_pkg::to_field(plane_x_q);
      plane_y_out_q <= vvr_pkg::to_field(plane_y_q);
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.dir_x_out   = dir_x_out_q;
  assign res_o.dir_y_out   = dir_y_out_q;
  assign res_o.plane_x_out = plane_x_out_q;
  assign res_o.plane_y_out = plane_y_out_q;

  vvr_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  vvr_cordic u_cordic (
    .clk_i     (clk_i),
    .ctrl_i    (cdc_ctrl),
    .bau_i     (bau),
    .dir_x_i   (dir_x_q),
    .dir_y_i   (dir_y_q),
    .plane_x_i (plane_x_q),
    .plane_y_i (plane_y_q),
    .dir_x_o   (cx_dir),
    .dir_y_o   (cy_dir),
    .plane_x_o (cx_pl),
    .plane_y_o (cy_pl)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/vvr_checker.sv =====
`default_nettype none

`include "view_vector_rotator_top_macros.svh"

// Port-level checks for the rotator.
module vvr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [vvr_pkg::FIELD_W-1:0] dir_x_i,
  input logic [vvr_pkg::FIELD_W-1:0] dir_y_i,
  input logic [vvr_pkg::FIELD_W-1:0] plane_x_i,
  input logic [vvr_pkg::FIELD_W-1:0] plane_y_i
);

  logic in_acc, out_acc;

  assign in_acc   = in_valid_i && in_ready_i;
  assign out_acc  = out_valid_i && out_ready_i;

  // one word in flight: busy straight after an accept
  `VVR_ASSERT_NEXT(a_busy_after_accept, in_acc, !in_ready_i, "ready after accept")
  // a delivered word is never offered twice
  `VVR_ASSERT_NEXT(a_no_repeat, out_acc, !out_valid_i, "result repeated")
  // a new result only appears from a busy datapath
  `VVR_ASSERT(a_result_from_work, $rose(out_valid_i) |-> $past(!in_ready_i),
              "result without work")
  `VVR_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(dir_x_i) && $stable(dir_y_i) &&
                   $stable(plane_x_i) && $stable(plane_y_i),
                   "stalled result changed")

endmodule

bind view_vector_rotator_top vvr_checker u_vvr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .dir_x_i     (res_o.dir_x_out),
  .dir_y_i     (res_o.dir_y_out),
  .plane_x_i   (res_o.plane_x_out),
  .plane_y_i   (res_o.plane_y_out)
);

`default_nettype wire
